// ===== hdl/byte_ring_fifo_assert.svh =====
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Concurrent assertion wrappers that can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_ASSERT_SVH
`define BYTE_RING_FIFO_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every clock edge outside reset.
`define BRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define BRF_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`else

`define BRF_ASSERT(lbl, prop, msg)
`define BRF_ASSERT_NEXT(lbl, cond, nxt, msg)

`endif

`endif

// ===== hdl/brf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Operation codes, field widths and the command and response records that
// pass between the control logic, the byte lanes and the merge stage.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned STAT_W  = 12;
  localparam int unsigned ROW_MAX_W  = 16;
  localparam int unsigned LANE_MAX_W = 3;
  localparam int unsigned CAP_RESET  = 4096;

  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DROP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  typedef struct packed {
    logic                   wr;
    logic                   rd;
    logic [COUNT_W-1:0]     count;
    logic [LANE_MAX_W-1:0]  lane_start;
    logic [ROW_MAX_W-1:0]   row;
  } lane_cmd_t;

  typedef struct packed {
    logic [LANE_MAX_W-1:0]  offset;
    logic [7:0]             data;
  } lane_rsp_t;

endpackage

// ===== hdl/brf_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring FIFO lane
// One byte bank of the store. The lane works out which byte of the beat
// falls on it and which row it touches, writes that byte and reads its row.
// ----------------------------------------------------------------------------
module brf_lane #(
  parameter int unsigned ROWS  = 512,
  parameter int unsigned LANES = 8,
  parameter int unsigned LANE  = 0
) (
  input  logic                              clk_i,
  input  brf_pkg::lane_cmd_t                cmd_i,
  input  logic [brf_pkg::DATA_W-1:0]        wr_bytes_i,
  output brf_pkg::lane_rsp_t                rsp_o
);

  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [7:0]    mem_q [ROWS];
  logic [7:0]    rd_q;
  logic [LW-1:0] off_q;

  logic [LW-1:0] start;
  logic [LW-1:0] offset;
  logic [RW-1:0] row;
  logic [RW-1:0] row_addr;
  logic [3:0]    wrap_off;
  logic          hit;

  always_comb begin
    start    = cmd_i.lane_start[LW-1:0];
    row      = cmd_i.row[RW-1:0];
    wrap_off = 4'(LANE + LANES) - 4'(start);
    if (LW'(LANE) >= start) begin
      offset   = LW'(LANE) - start;
      row_addr = row;
    end else begin
      offset   = wrap_off[LW-1:0];
      row_addr = (row == RW'(ROWS - 1)) ? '0 : row + RW'(1);
    end
    hit = 4'(offset) < cmd_i.count;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && hit) begin
      mem_q[row_addr] <= wr_bytes_i[{offset, 3'b000} +: 8];
    end
    if (cmd_i.rd) begin
      rd_q  <= mem_q[row_addr];
      off_q <= offset;
    end
  end

  assign rsp_o.offset = brf_pkg::LANE_MAX_W'(off_q);
  assign rsp_o.data   = rd_q;

endmodule

// ===== hdl/brf_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring FIFO merge stage
// Places each lane's byte at its position in the beat and clears the
// positions beyond the number of bytes moved.
// ----------------------------------------------------------------------------
module brf_merge #(
  parameter int unsigned LANES = 8
) (
  input  brf_pkg::lane_rsp_t                rsp_i [LANES],
  input  logic [brf_pkg::COUNT_W-1:0]       count_i,
  output logic [brf_pkg::DATA_W-1:0]        read_bytes_o
);

  always_comb begin
    read_bytes_o = '0;
    for (int k = 0; k < LANES; k++) begin
      if (4'(rsp_i[k].offset) < count_i) begin
        read_bytes_o = read_bytes_o |
          (brf_pkg::DATA_W'(rsp_i[k].data) << {rsp_i[k].offset, 3'b000});
      end
    end
  end

endmodule

// ===== hdl/byte_ring_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring FIFO
// Circular byte FIFO with one slot kept empty. Each beat writes, reads,
// peeks, drops or clears up to LANES bytes, spread over LANES byte banks.
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_we_i                cfg_wdata_i (capacity)
//   in       in         in_valid_i/in_ready_o   kind, write_bytes, byte_count
//   out      out        out_valid_o/out_ready_i read_bytes, bytes_moved,
//                                               accepted, used_count, free_count
//
// After an input beat is accepted, its result passes the registered bank read
// and then the merge into the output register. The next input beat is taken in
// the cycle the result is taken, so no new beat enters while a result waits.
// Reset empties the ring and sets the capacity to 4096, limited to DEPTH.
// A stall on the output holds the result and blocks new input beats.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_assert.svh"

module byte_ring_fifo #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned LANES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [brf_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [brf_pkg::KIND_W-1:0]        kind_i,
  input  logic [brf_pkg::DATA_W-1:0]        write_bytes_i,
  input  logic [brf_pkg::COUNT_W-1:0]       byte_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [brf_pkg::DATA_W-1:0]        read_bytes_o,
  output logic [brf_pkg::COUNT_W-1:0]       bytes_moved_o,
  output logic                              accepted_o,
  output logic [brf_pkg::STAT_W-1:0]        used_count_o,
  output logic [brf_pkg::STAT_W-1:0]        free_count_o
);

  localparam int unsigned ROWS = (DEPTH + LANES - 1) / LANES;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LW   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CAP_INIT =
    (DEPTH < brf_pkg::CAP_RESET) ? DEPTH : brf_pkg::CAP_RESET;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MERGE = 3'b010,
    S_OUT   = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cap_q;
  logic [PW-1:0] used_q, used_d;
  logic [RW-1:0] wrow_q, wrow_d, rrow_q, rrow_d;
  logic [LW-1:0] wlane_q, wlane_d, rlane_q, rlane_d;
  logic          rd_kind_q;

  logic [brf_pkg::DATA_W-1:0]  read_bytes_q;
  logic [brf_pkg::COUNT_W-1:0] moved_q, moved_d;
  logic                        acc_q, acc_d;
  logic [brf_pkg::STAT_W-1:0]  usedc_q, freec_q;

  logic                        in_fire;
  logic [brf_pkg::COUNT_W-1:0] cnt, n_rd;
  logic [CW-1:0]               free_now, free_d, cap_eff;
  logic                        wr_ok, wr_en, rd_en;
  logic [3:0]                  wsum, rsum;
  logic [RW-1:0]               wrow_inc, rrow_inc;
  logic [LW-1:0]               wlane_adv, rlane_adv;
  logic [RW-1:0]               wrow_adv, rrow_adv;

  brf_pkg::lane_cmd_t          cmd;
  brf_pkg::lane_rsp_t          rsp [LANES];
  logic [brf_pkg::COUNT_W-1:0] merge_count;
  logic [brf_pkg::DATA_W-1:0]  merged;

  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_OUT) && out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (cfg_wdata_i < brf_pkg::CFG_W'(2)) begin
      cap_eff = CW'(2);
    end else if (32'(cfg_wdata_i) > 32'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cfg_wdata_i);
    end
  end

  always_comb begin
    cnt      = (byte_count_i > 4'(LANES)) ? 4'(LANES) : byte_count_i;
    free_now = cap_q - CW'(1) - CW'(used_q);
    wr_ok    = free_now >= CW'(cnt);
    n_rd     = (CW'(used_q) < CW'(cnt)) ? 4'(used_q) : cnt;

    wrow_inc = (wrow_q == RW'(ROWS - 1)) ? '0 : wrow_q + RW'(1);
    rrow_inc = (rrow_q == RW'(ROWS - 1)) ? '0 : rrow_q + RW'(1);
    wsum     = 4'(wlane_q) + cnt;
    rsum     = 4'(rlane_q) + n_rd;
    if (wsum >= 4'(LANES)) begin
      wlane_adv = LW'(wsum - 4'(LANES));
      wrow_adv  = wrow_inc;
    end else begin
      wlane_adv = LW'(wsum);
      wrow_adv  = wrow_q;
    end
    if (rsum >= 4'(LANES)) begin
      rlane_adv = LW'(rsum - 4'(LANES));
      rrow_adv  = rrow_inc;
    end else begin
      rlane_adv = LW'(rsum);
      rrow_adv  = rrow_q;
    end

    used_d  = used_q;
    wrow_d  = wrow_q;
    wlane_d = wlane_q;
    rrow_d  = rrow_q;
    rlane_d = rlane_q;
    moved_d = '0;
    acc_d   = 1'b1;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    case (kind_i)
      brf_pkg::KIND_WRITE: begin
        if (wr_ok) begin
          wr_en   = 1'b1;
          moved_d = cnt;
          used_d  = used_q + PW'(cnt);
          wrow_d  = wrow_adv;
          wlane_d = wlane_adv;
        end else begin
          acc_d = 1'b0;
        end
      end
      brf_pkg::KIND_READ: begin
        rd_en   = 1'b1;
        moved_d = n_rd;
        used_d  = used_q - PW'(n_rd);
        rrow_d  = rrow_adv;
        rlane_d = rlane_adv;
      end
      brf_pkg::KIND_PEEK: begin
        rd_en   = 1'b1;
        moved_d = n_rd;
      end
      brf_pkg::KIND_DROP: begin
        moved_d = n_rd;
        used_d  = used_q - PW'(n_rd);
        rrow_d  = rrow_adv;
        rlane_d = rlane_adv;
      end
      brf_pkg::KIND_CLEAR: begin
        used_d  = '0;
        wrow_d  = '0;
        wlane_d = '0;
        rrow_d  = '0;
        rlane_d = '0;
      end
      default: begin
      end
    endcase
    free_d = cap_q - CW'(1) - CW'(used_d);
  end

  always_comb begin
    cmd.wr         = in_fire && wr_en;
    cmd.rd         = in_fire && rd_en;
    cmd.count      = moved_d;
    cmd.lane_start = brf_pkg::LANE_MAX_W'(wr_en ? wlane_q : rlane_q);
    cmd.row        = brf_pkg::ROW_MAX_W'(wr_en ? wrow_q : rrow_q);
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    brf_lane #(
      .ROWS  (ROWS),
      .LANES (LANES),
      .LANE  (k)
    ) u_lane (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .wr_bytes_i (write_bytes_i),
      .rsp_o      (rsp[k])
    );
  end

  assign merge_count = rd_kind_q ? moved_q : '0;

  brf_merge #(
    .LANES (LANES)
  ) u_merge (
    .rsp_i        (rsp),
    .count_i      (merge_count),
    .read_bytes_o (merged)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (in_fire) begin
          state_d = S_MERGE;
        end else if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CW'(CAP_INIT);
      used_q  <= '0;
      wrow_q  <= '0;
      wlane_q <= '0;
      rrow_q  <= '0;
      rlane_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q   <= cap_eff;
        used_q  <= '0;
        wrow_q  <= '0;
        wlane_q <= '0;
        rrow_q  <= '0;
        rlane_q <= '0;
      end else if (in_fire) begin
        used_q  <= used_d;
        wrow_q  <= wrow_d;
        wlane_q <= wlane_d;
        rrow_q  <= rrow_d;
        rlane_q <= rlane_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      moved_q   <= moved_d;
      acc_q     <= acc_d;
      usedc_q   <= brf_pkg::STAT_W'(used_d);
      freec_q   <= brf_pkg::STAT_W'(free_d);
      rd_kind_q <= rd_en;
    end
    if (state_q == S_MERGE) begin
      read_bytes_q <= merged;
    end
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign read_bytes_o  = read_bytes_q;
  assign bytes_moved_o = moved_q;
  assign accepted_o    = acc_q;
  assign used_count_o  = usedc_q;
  assign free_count_o  = freec_q;

  `BRF_ASSERT(a_used_below_cap, (CW'(used_q) < cap_q), "Used count reached the capacity.")
  `BRF_ASSERT(a_refused_moves_none, (out_valid_o && !accepted_o |-> bytes_moved_o == '0), "A refused write moved bytes.")
  `BRF_ASSERT(a_counts_sum, (out_valid_o |-> 12'(used_count_o + free_count_o) == 12'(cap_q - CW'(1))), "Used and free do not add up to the capacity less one.")
  `BRF_ASSERT_NEXT(a_merge_then_out, state_q == S_MERGE, state_q == S_OUT, "Merge cycle not followed by a result.")

endmodule

// ===== test/byte_ring_fifo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring FIFO checker
// Watches the capacity port and both beat channels, keeps its own copy of the
// ring and its pointers, and compares every output beat field by field with
// the oldest predicted reply.
// ----------------------------------------------------------------------------
module byte_ring_fifo_checker #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned LANES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brf_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [brf_pkg::KIND_W-1:0]   kind_i,
  input  logic [brf_pkg::DATA_W-1:0]   write_bytes_i,
  input  logic [brf_pkg::COUNT_W-1:0]  byte_count_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [brf_pkg::DATA_W-1:0]   read_bytes_i,
  input  logic [brf_pkg::COUNT_W-1:0]  bytes_moved_i,
  input  logic                         accepted_i,
  input  logic [brf_pkg::STAT_W-1:0]   used_count_i,
  input  logic [brf_pkg::STAT_W-1:0]   free_count_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import brf_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  read_bytes;
    logic [COUNT_W-1:0] moved;
    logic               accepted;
    logic [STAT_W-1:0]  used;
    logic [STAT_W-1:0]  free_space;
  } fifo_reply_t;

  logic [7:0]        ring_mem [DEPTH];
  int unsigned       head_idx;
  int unsigned       tail_idx;
  logic [CFG_W-1:0]  capacity_reg;
  fifo_reply_t       reply_q [$];
  int                fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic int unsigned ring_size();
    if (capacity_reg < 2) return 2;
    if (capacity_reg > DEPTH) return DEPTH;
    return capacity_reg;
  endfunction

  function automatic int unsigned fill_level(input int unsigned size);
    if (head_idx > tail_idx) return size - head_idx + tail_idx;
    return tail_idx - head_idx;
  endfunction

  function automatic fifo_reply_t apply_fifo_op(input logic [KIND_W-1:0] kind,
                                                input logic [DATA_W-1:0] data,
                                                input logic [COUNT_W-1:0] req);
    int unsigned size;
    int unsigned used;
    int unsigned count;
    int unsigned n;
    int unsigned p;
    int unsigned i;
    fifo_reply_t rep;
    size = ring_size();
    rep = '0;
    rep.accepted = 1'b1;
    if (head_idx >= size) head_idx = 0;
    if (tail_idx >= size) tail_idx = 0;
    count = (req > LANES) ? LANES : req;
    used = fill_level(size);
    n = (count < used) ? count : used;
    case (kind)
      KIND_WRITE: begin
        if (size - used - 1 < count) begin
          rep.accepted = 1'b0;
        end else begin
          p = tail_idx;
          for (i = 0; i < count; i++) begin
            ring_mem[p] = data[8*i +: 8];
            p = (p + 1 == size) ? 0 : p + 1;
          end
          tail_idx = p;
          rep.moved = count[COUNT_W-1:0];
        end
      end
      KIND_READ, KIND_PEEK: begin
        p = head_idx;
        for (i = 0; i < n; i++) begin
          rep.read_bytes[8*i +: 8] = ring_mem[p];
          p = (p + 1 == size) ? 0 : p + 1;
        end
        if (kind == KIND_READ) head_idx = p;
        rep.moved = n[COUNT_W-1:0];
      end
      KIND_DROP: begin
        head_idx = (head_idx + n >= size) ? head_idx + n - size : head_idx + n;
        rep.moved = n[COUNT_W-1:0];
      end
      KIND_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
      end
      default: ;
    endcase
    used = fill_level(size);
    rep.used = used[STAT_W-1:0];
    p = size - used - 1;
    rep.free_space = p[STAT_W-1:0];
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fifo_reply_t want;
    if (!rst_ni) begin
      head_idx = 0;
      tail_idx = 0;
      capacity_reg = CAP_RESET;
      reply_q.delete();
    end else begin
      if (cfg_we_i) begin
        capacity_reg = cfg_wdata_i;
        head_idx = 0;
        tail_idx = 0;
      end
      if (in_valid_i && in_ready_i) begin
        reply_q.push_back(apply_fifo_op(kind_i, write_bytes_i, byte_count_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          report_error("output beat with no beat waiting for it");
        end else begin
          want = reply_q.pop_front();
          compare_field("read_bytes", read_bytes_i, want.read_bytes);
          compare_field("bytes_moved", bytes_moved_i, want.moved);
          compare_field("accepted", accepted_i, want.accepted);
          compare_field("used_count", used_count_i, want.used);
          compare_field("free_count", free_count_i, want.free_space);
        end
      end
    end
    pending_o = reply_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring FIFO testbench
// Drives directed and random write, read, peek, drop, clear and spare-kind beats
// over a range of ring capacities with random gaps and output stalls, and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CLK_HALF    = 6;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [brf_pkg::KIND_W-1:0] KIND_SPARE_0 = 3'd5;
  localparam logic [brf_pkg::KIND_W-1:0] KIND_SPARE_1 = 3'd6;
  localparam logic [brf_pkg::KIND_W-1:0] KIND_SPARE_2 = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [brf_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [brf_pkg::KIND_W-1:0]    kind = '0;
  logic [brf_pkg::DATA_W-1:0]    write_bytes = '0;
  logic [brf_pkg::COUNT_W-1:0]   byte_count = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [brf_pkg::DATA_W-1:0]    read_bytes;
  logic [brf_pkg::COUNT_W-1:0]   bytes_moved;
  logic                          accepted;
  logic [brf_pkg::STAT_W-1:0]    used_count;
  logic [brf_pkg::STAT_W-1:0]    free_count;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  byte_ring_fifo u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .write_bytes_i (write_bytes),
    .byte_count_i  (byte_count),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_bytes_o  (read_bytes),
    .bytes_moved_o (bytes_moved),
    .accepted_o    (accepted),
    .used_count_o  (used_count),
    .free_count_o  (free_count)
  );

  byte_ring_fifo_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .write_bytes_i (write_bytes),
    .byte_count_i  (byte_count),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .read_bytes_i  (read_bytes),
    .bytes_moved_i (bytes_moved),
    .accepted_i    (accepted),
    .used_count_i  (used_count),
    .free_count_i  (free_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  task automatic send_op(input logic [brf_pkg::KIND_W-1:0] op,
                         input logic [brf_pkg::DATA_W-1:0] data,
                         input logic [brf_pkg::COUNT_W-1:0] cnt);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    kind        <= op;
    write_bytes <= data;
    byte_count  <= cnt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // The ring must be idle when the capacity changes, since a write empties it.
  task automatic write_capacity(input logic [brf_pkg::CFG_W-1:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_mix(input int unsigned n, input int unsigned write_pct,
                         input bit wide);
    int unsigned j;
    int unsigned r;
    logic [brf_pkg::KIND_W-1:0]  op;
    logic [brf_pkg::COUNT_W-1:0] cnt;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < write_pct) begin
        op = brf_pkg::KIND_WRITE;
      end else begin
        r = $urandom_range(0, 19);
        if (r < 7) op = brf_pkg::KIND_READ;
        else if (r < 11) op = brf_pkg::KIND_PEEK;
        else if (r < 15) op = brf_pkg::KIND_DROP;
        else if (r < 17) op = brf_pkg::KIND_CLEAR;
        else op = KIND_SPARE_0 + 3'($urandom_range(0, 2));
      end
      if (wide && $urandom_range(0, 9) != 0) cnt = 4'd8;
      else if ($urandom_range(0, 9) == 0) cnt = 4'($urandom_range(9, 15));
      else cnt = 4'($urandom_range(0, 8));
      send_op(op, {$urandom, $urandom}, cnt);
    end
  endtask

  task automatic run_directed();
    send_op(brf_pkg::KIND_WRITE, {$urandom, $urandom}, 4'd0);
    send_op(brf_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_op(brf_pkg::KIND_WRITE, 64'h0, 4'd8);
    send_op(brf_pkg::KIND_PEEK, 64'h0, 4'd8);
    send_op(brf_pkg::KIND_READ, 64'h0, 4'd15);
    send_op(brf_pkg::KIND_READ, 64'h0, 4'd8);
    send_op(brf_pkg::KIND_READ, 64'h0, 4'd8);
    send_op(brf_pkg::KIND_WRITE, 64'h0123_4567_89AB_CDEF, 4'd3);
    send_op(brf_pkg::KIND_DROP, 64'h0, 4'd12);
    send_op(brf_pkg::KIND_WRITE, {$urandom, $urandom}, 4'd5);
    send_op(brf_pkg::KIND_CLEAR, {$urandom, $urandom}, 4'd8);
    send_op(KIND_SPARE_0, {$urandom, $urandom}, 4'd8);
    send_op(KIND_SPARE_1, {$urandom, $urandom}, 4'd3);
    send_op(KIND_SPARE_2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    send_op(brf_pkg::KIND_PEEK, 64'h0, 4'd0);
    // A capacity of zero acts as the smallest ring: one byte of room.
    write_capacity(13'd0);
    send_op(brf_pkg::KIND_WRITE, {$urandom, $urandom}, 4'd2);
    send_op(brf_pkg::KIND_WRITE, 64'hA5, 4'd1);
    send_op(brf_pkg::KIND_WRITE, 64'h5A, 4'd1);
    send_op(brf_pkg::KIND_PEEK, 64'h0, 4'd8);
    send_op(brf_pkg::KIND_READ, 64'h0, 4'd8);
    send_op(brf_pkg::KIND_WRITE, 64'h3C, 4'd1);
    send_op(brf_pkg::KIND_DROP, 64'h0, 4'd0);
    send_op(brf_pkg::KIND_READ, 64'h0, 4'd1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    write_capacity(13'd2);
    run_mix(20, 50, 1'b0);
    calm = 1'b1;
    write_capacity(13'd1);
    run_mix(15, 50, 1'b0);
    calm = 1'b0;
    write_capacity(13'd9);
    run_mix(15, 55, 1'b0);
    write_capacity(13'd17);
    run_mix(15, 55, 1'b0);
    // A capacity above the depth acts as the full depth; fill it, then wrap.
    write_capacity(13'd8191);
    run_mix(560, 100, 1'b1);
    run_mix(30, 35, 1'b0);
    write_capacity(13'd100);
    run_mix(15, 50, 1'b0);
    calm = 1'b1;
    write_capacity(13'd4097);
    run_mix(10, 50, 1'b0);
    calm = 1'b0;
    write_capacity(13'd50);
    run_mix(10, 50, 1'b0);
    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
